>>> hw/rtl/set_assoc_lru_writeback_cache_defines.svh
// Assertion macros shared by the cache checker.
// No dependencies.
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
// Assert that a condition holds at every edge.
`define SALC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`endif

>>> hw/rtl/salc_pkg.sv
// Types and constants for the set-associative LRU write-back cache.
// No dependencies.
package salc_pkg;
	localparam int BLOCK_BYTES = 16;
	localparam int SETS = 32;
	localparam int WAYS = 2;
	localparam int ADDR_W = 32;
	localparam int CNT_W = 32;
	localparam logic REQ_READ = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction
endpackage

>>> hw/rtl/salc_front.sv
// Front end: accepts transactions and hands them to a two-entry queue.
// Depends on salc_pkg.
module salc_front #(
	parameter int ADDR_W = salc_pkg::ADDR_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              in_type,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              q_valid,
	input  logic              q_pop,
	output logic              q_type,
	output logic [ADDR_W-1:0] q_addr
);
	logic [1:0]        cnt_q;
	logic              rd_q, wr_q;
	logic [ADDR_W:0]   ent_q [2];
	logic              push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign {q_type, q_addr} = ent_q[rd_q];

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// Hold entries.
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= {in_type, in_addr};
	end
endmodule

>>> hw/rtl/salc_back.sv
// Back end: set lookup, LRU victim choice, update and result register.
// Depends on salc_pkg.
module salc_back #(
	parameter int BLOCK_BYTES = salc_pkg::BLOCK_BYTES,
	parameter int SETS = salc_pkg::SETS,
	parameter int WAYS = salc_pkg::WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  logic        q_type,
	input  logic [31:0] q_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic        writeback,
	output logic [31:0] victim_address,
	output logic [31:0] read_count,
	output logic [31:0] read_miss_count,
	output logic [31:0] write_count,
	output logic [31:0] write_miss_count,
	output logic [31:0] writeback_count
);
	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SET_B = $clog2(SETS);
	localparam int TAG_W = 32 - OFF_W - SET_B;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINES = SETS * WAYS;
	localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [LINES-1:0] valid_q, dirty_q;
	logic [TAG_W-1:0] tag_mem [LINES];
	logic [31:0]      addr_mem [LINES];
	logic [31:0]      stamp_mem [LINES];
	logic [31:0]      set_cnt_q [SETS];
	logic [SETS-1:0]  set_used_q;
	logic [TAG_W-1:0] rd_tag_s1 [WAYS];
	logic [31:0]      rd_addr_s1 [WAYS];
	logic [31:0]      rd_stamp_s1 [WAYS];
	logic             type_s1;
	logic [31:0]      addr_s1;
	logic [SET_W-1:0] set_s1;
	logic [31:0]      nrd_q, nwr_q, nrm_q, nwm_q, nwb_q;

	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_s1;
	logic             hit_c, free_c, wb_c;
	logic [WAY_W-1:0] hit_way, free_way, lru_way, slot;
	logic [LINE_W-1:0] slot_idx;
	logic [31:0]      min_st, stamp_c;

	assign tag_s1 = addr_s1[31 -: TAG_W];
	always_comb begin
		set_in = '0;
		if (SETS > 1) set_in = SET_W'(q_addr[OFF_W +: SET_W]);
	end

	// Compare tags, find free way and LRU way.
	always_comb begin
		hit_c = 1'b0; hit_way = '0; free_c = 1'b0; free_way = '0;
		lru_way = '0; min_st = rd_stamp_s1[0];
		for (int w = 0; w < WAYS; w++) begin
			if (valid_q[LINE_W'(set_s1*WAYS + w)]) begin
				if (!hit_c && rd_tag_s1[w] == tag_s1) begin
					hit_c = 1'b1; hit_way = WAY_W'(w);
				end
			end else if (!free_c) begin
				free_c = 1'b1; free_way = WAY_W'(w);
			end
			if (w > 0 && rd_stamp_s1[w] < min_st) begin
				min_st = rd_stamp_s1[w]; lru_way = WAY_W'(w);
			end
		end
		slot = hit_c ? hit_way : (free_c ? free_way : lru_way);
		slot_idx = LINE_W'(set_s1*WAYS + slot);
		wb_c = !hit_c && !free_c && dirty_q[slot_idx];
		stamp_c = set_used_q[set_s1] ? set_cnt_q[set_s1] : '0;
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_valid = (state_q == ST_DONE);
	assign read_count = nrd_q;
	assign write_count = nwr_q;
	assign read_miss_count = nrm_q;
	assign write_miss_count = nwm_q;
	assign writeback_count = nwb_q;

	// Read the set's ways; in the compare state, write the chosen line and register the result.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			type_s1 <= q_type;
			addr_s1 <= q_addr;
			set_s1 <= set_in;
			for (int w = 0; w < WAYS; w++) begin
				rd_tag_s1[w] <= tag_mem[LINE_W'(set_in*WAYS + w)];
				rd_addr_s1[w] <= addr_mem[LINE_W'(set_in*WAYS + w)];
				rd_stamp_s1[w] <= stamp_mem[LINE_W'(set_in*WAYS + w)];
			end
		end
		if (state_q == ST_LOOK) begin
			stamp_mem[slot_idx] <= stamp_c;
			set_cnt_q[set_s1] <= salc_pkg::sat_inc(stamp_c);
			if (!hit_c) begin
				tag_mem[slot_idx] <= tag_s1;
				addr_mem[slot_idx] <= addr_s1;
			end
			writeback <= wb_c;
			victim_address <= wb_c ? rd_addr_s1[slot] : '0;
			hit <= hit_c;
		end
	end

	// Sequence and update control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0; dirty_q <= '0; set_used_q <= '0;
			nrd_q <= '0; nwr_q <= '0; nrm_q <= '0; nwm_q <= '0; nwb_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (q_pop) state_q <= ST_LOOK;
				ST_LOOK: begin
					state_q <= ST_DONE;
					set_used_q[set_s1] <= 1'b1;
					valid_q[slot_idx] <= 1'b1;
					if (type_s1 == salc_pkg::REQ_WRITE) begin
						dirty_q[slot_idx] <= 1'b1;
						nwr_q <= salc_pkg::sat_inc(nwr_q);
						if (!hit_c) nwm_q <= salc_pkg::sat_inc(nwm_q);
					end else begin
						if (!hit_c) dirty_q[slot_idx] <= 1'b0;
						nrd_q <= salc_pkg::sat_inc(nrd_q);
						if (!hit_c) nrm_q <= salc_pkg::sat_inc(nrm_q);
					end
					if (wb_c) nwb_q <= salc_pkg::sat_inc(nwb_q);
				end
				ST_DONE: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hw/rtl/set_assoc_lru_writeback_cache.sv
// Top level of the set-associative LRU write-back cache.
// Depends on salc_pkg, salc_front, salc_back.
//  channel | signals                          | direction
//  request | req_valid req_stall req_type address | in
//  result  | rsp_valid rsp_stall hit ... counts    | out
// In the back end a transaction passes through set read, compare and update, and result.
// The front queue holds two transactions, so requests are taken while a result waits.
// Reset clears valid and dirty bits, set-used flags (so set stamps restart at zero) and totals at once.
// A stalled result holds the back end; the queue then fills and stalls requests.
module set_assoc_lru_writeback_cache #(
	parameter int BLOCK_BYTES = salc_pkg::BLOCK_BYTES,
	parameter int SETS = salc_pkg::SETS,
	parameter int WAYS = salc_pkg::WAYS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [31:0] address,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic        writeback,
	output logic [31:0] victim_address,
	output logic [31:0] read_count,
	output logic [31:0] read_miss_count,
	output logic [31:0] write_count,
	output logic [31:0] write_miss_count,
	output logic [31:0] writeback_count
);
	logic        q_valid, q_pop, q_type;
	logic [31:0] q_addr;

	salc_front #(.ADDR_W(32)) u_front (
		.clk, .arst_n, .in_valid(req_valid), .in_stall(req_stall), .in_type(req_type),
		.in_addr(address), .q_valid, .q_pop, .q_type, .q_addr
	);

	salc_back #(.BLOCK_BYTES(BLOCK_BYTES), .SETS(SETS), .WAYS(WAYS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_type, .q_addr,
		.out_valid(rsp_valid), .out_stall(rsp_stall), .hit, .writeback, .victim_address,
		.read_count, .read_miss_count, .write_count, .write_miss_count, .writeback_count
	);
endmodule

>>> hw/rtl/salc_checker.sv
// Port-level checker for the cache, bound to the top level.
// Depends on set_assoc_lru_writeback_cache_defines.svh.
`include "set_assoc_lru_writeback_cache_defines.svh"
module salc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic        hit,
	input logic        writeback,
	input logic [31:0] victim_address,
	input logic [31:0] writeback_count
);
	`SALC_ASSERT_NEXT(a_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(victim_address))
	`SALC_ASSERT_ALWAYS(a_hit_no_wb, clk, arst_n, !(rsp_valid && hit && writeback))
	`SALC_ASSERT_ALWAYS(a_va_zero, clk, arst_n, !(rsp_valid && !writeback && victim_address != 32'd0))
	`SALC_ASSERT_ALWAYS(a_wbcnt, clk, arst_n, !(rsp_valid && writeback && writeback_count == 32'd0))
endmodule

bind set_assoc_lru_writeback_cache salc_checker u_salc_checker (
	.clk, .arst_n, .rsp_valid, .rsp_stall, .hit, .writeback, .victim_address, .writeback_count
);

>>> tb/tb.sv
// Testbench for set_assoc_lru_writeback_cache: drives read and write accesses,
// predicts hit, eviction, writeback and running totals, and checks every result.
// Depends on salc_pkg and the cache top level.
module tb;
	localparam int LINES = salc_pkg::SETS * salc_pkg::WAYS;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        hit;
		logic        writeback;
		logic [31:0] victim_address;
		logic [31:0] read_count;
		logic [31:0] read_miss_count;
		logic [31:0] write_count;
		logic [31:0] write_miss_count;
		logic [31:0] writeback_count;
	} access_result_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic        req_type;
	logic [31:0] address;
	logic        rsp_valid;
	logic        rsp_stall;
	logic        hit;
	logic        writeback;
	logic [31:0] victim_address;
	logic [31:0] read_count;
	logic [31:0] read_miss_count;
	logic [31:0] write_count;
	logic [31:0] write_miss_count;
	logic [31:0] writeback_count;

	// shadow cache state
	logic        sh_valid [LINES];
	logic        sh_dirty [LINES];
	logic [22:0] sh_tag [LINES];
	logic [31:0] sh_addr [LINES];
	logic [31:0] sh_stamp [LINES];
	logic [31:0] sh_set_stamp [salc_pkg::SETS];
	logic [31:0] sh_reads, sh_writes, sh_read_misses, sh_write_misses, sh_writebacks;

	access_result_t expected_results [$];
	int  error_count;
	int  idle_cycles;
	bit  timed_out;
	bit  rsp_stall_free;

	set_assoc_lru_writeback_cache i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .address(address),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.hit(hit), .writeback(writeback), .victim_address(victim_address),
		.read_count(read_count), .read_miss_count(read_miss_count),
		.write_count(write_count), .write_miss_count(write_miss_count),
		.writeback_count(writeback_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// predict one access and update the shadow state
	function automatic access_result_t predict_access(input logic is_wr,
			input logic [31:0] addr);
		access_result_t r;
		logic [27:0] blk;
		int set_idx, base, slot, free_way, vw;
		logic [22:0] tg;
		blk = 28'(addr / salc_pkg::BLOCK_BYTES);
		set_idx = int'(blk % salc_pkg::SETS);
		tg = 23'(blk / salc_pkg::SETS);
		base = set_idx * salc_pkg::WAYS;
		free_way = -1;
		r = '0;
		if (is_wr == salc_pkg::REQ_WRITE) sh_writes = bump(sh_writes);
		else sh_reads = bump(sh_reads);
		for (int w = 0; w < salc_pkg::WAYS; w++) begin
			if (!r.hit) begin
				if (sh_valid[base+w]) begin
					if (sh_tag[base+w] == tg) begin
						if (is_wr == salc_pkg::REQ_WRITE) sh_dirty[base+w] = 1'b1;
						sh_stamp[base+w] = sh_set_stamp[set_idx];
						sh_set_stamp[set_idx] = bump(sh_set_stamp[set_idx]);
						r.hit = 1'b1;
					end
				end else if (free_way < 0) begin
					free_way = w;
				end
			end
		end
		if (!r.hit) begin
			if (free_way >= 0) begin
				slot = base + free_way;
			end else begin
				vw = 0;
				for (int w = 1; w < salc_pkg::WAYS; w++)
					if (sh_stamp[base+w] < sh_stamp[base+vw]) vw = w;
				slot = base + vw;
				if (sh_dirty[slot]) begin
					r.writeback = 1'b1;
					r.victim_address = sh_addr[slot];
					sh_writebacks = bump(sh_writebacks);
				end
			end
			sh_valid[slot] = 1'b1;
			sh_dirty[slot] = (is_wr == salc_pkg::REQ_WRITE);
			sh_tag[slot] = tg;
			sh_addr[slot] = addr;
			sh_stamp[slot] = sh_set_stamp[set_idx];
			sh_set_stamp[set_idx] = bump(sh_set_stamp[set_idx]);
			if (is_wr == salc_pkg::REQ_WRITE) sh_write_misses = bump(sh_write_misses);
			else sh_read_misses = bump(sh_read_misses);
		end
		r.read_count = sh_reads;
		r.read_miss_count = sh_read_misses;
		r.write_count = sh_writes;
		r.write_miss_count = sh_write_misses;
		r.writeback_count = sh_writebacks;
		return r;
	endfunction

	// send one access; hold it until accepted, then maybe open a gap
	task automatic send_access(input logic is_wr, input logic [31:0] addr);
		req_valid <= 1'b1;
		req_type <= is_wr;
		address <= addr;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_results.insert(expected_results.size(), predict_access(is_wr, addr));
		if ($urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] make_addr(input int set_idx, input logic [22:0] tg,
			input logic [3:0] offs);
		return {tg, set_idx[4:0], offs};
	endfunction

	// corners: all-zero and all-one addresses and both access kinds
	task automatic test_field_extremes();
		send_access(salc_pkg::REQ_READ, 32'h0000_0000);
		send_access(salc_pkg::REQ_WRITE, 32'hFFFF_FFFF);
		send_access(salc_pkg::REQ_WRITE, 32'h0000_000F);
		send_access(salc_pkg::REQ_READ, 32'hFFFF_FFF0);
	endtask

	// fill a set, dirty its ways, then evict for clean and dirty victims
	task automatic test_eviction();
		send_access(salc_pkg::REQ_READ, make_addr(3, 23'd1, 4'h0));
		send_access(salc_pkg::REQ_READ, make_addr(3, 23'd2, 4'h4));
		send_access(salc_pkg::REQ_READ, make_addr(3, 23'd3, 4'h8));
		send_access(salc_pkg::REQ_WRITE, make_addr(3, 23'd2, 4'h1));
		send_access(salc_pkg::REQ_WRITE, make_addr(3, 23'd3, 4'h2));
		send_access(salc_pkg::REQ_READ, make_addr(3, 23'd4, 4'h3));
		send_access(salc_pkg::REQ_WRITE, make_addr(3, 23'd5, 4'h5));
		send_access(salc_pkg::REQ_READ, make_addr(3, 23'd6, 4'h6));
		send_access(salc_pkg::REQ_READ, make_addr(3, 23'd7, 4'h7));
	endtask

	// random accesses over few tags per set so hits and evictions both occur
	task automatic test_random_traffic(input int count);
		logic [22:0] tg;
		int set_idx;
		for (int n = 0; n < count; n++) begin
			set_idx = int'($urandom_range(0, salc_pkg::SETS - 1));
			case ($urandom_range(0, 9))
				0: tg = 23'($urandom);
				1: tg = 23'h7F_FFFF - 23'($urandom_range(0, 2));
				default: tg = 23'($urandom_range(0, 3));
			endcase
			send_access(1'($urandom_range(0, 1)), make_addr(set_idx, tg, 4'($urandom)));
		end
	endtask

	// receiver stall pattern, with free stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rsp_stall_free <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) == 0) rsp_stall_free <= ~rsp_stall_free;
			rsp_stall <= rsp_stall_free ? 1'b0 : ($urandom_range(0, 3) == 0);
		end
	end

	// check each accepted result against the oldest prediction
	always @(posedge clk) begin
		access_result_t got, exp_r;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = '{hit, writeback, victim_address, read_count, read_miss_count,
				write_count, write_miss_count, writeback_count};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("FAIL set_assoc_lru_writeback_cache");
			$finish;
		end
	end

	initial begin
		int drain;
		req_valid <= 1'b0;
		req_type <= salc_pkg::REQ_READ;
		address <= '0;
		arst_n <= 1'b0;
		error_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		for (int i = 0; i < LINES; i++) begin
			sh_valid[i] = 1'b0;
			sh_dirty[i] = 1'b0;
			sh_tag[i] = '0;
			sh_addr[i] = '0;
			sh_stamp[i] = '0;
		end
		for (int s = 0; s < salc_pkg::SETS; s++) sh_set_stamp[s] = '0;
		{sh_reads, sh_writes, sh_read_misses, sh_write_misses, sh_writebacks} = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_eviction();
		test_random_traffic(2000);
		req_valid <= 1'b0;
		drain = 0;
		while (expected_results.size() != 0 && drain < IDLE_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("PASS set_assoc_lru_writeback_cache");
		else
			$display("FAIL set_assoc_lru_writeback_cache");
		$finish;
	end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/salc_pkg.sv
hw/rtl/salc_front.sv
hw/rtl/salc_back.sv
hw/rtl/set_assoc_lru_writeback_cache.sv
hw/rtl/salc_checker.sv
tb/tb.sv
